[hw/rtl/ffa_pkg.sv]
// Shared types and constants for the first-fit allocator.
// No dependencies; imported by the top level and the sequencer.
`timescale 1ns / 1ps

package ffa_pkg;

    // Defaults of the top-level parameters
    localparam int HEAP_SIZE_MAX_DEF = 4096;
    localparam int HEADER_BYTES_DEF  = 16;
    localparam int ALIGN_BYTES_DEF   = 8;

    // Fixed field widths and the reset heap size
    localparam int CFG_W          = 13;
    localparam int HEAP_BYTES_RST = 4096;
    localparam int OPC_W          = 2;
    localparam int REQ_W          = 16;
    localparam int ADDR_W         = 12;
    localparam int NEED_W         = REQ_W + 1;
    localparam int IN_W           = 32;
    localparam int OUT_W          = 16;

    typedef enum logic [OPC_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REINIT = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              ok;
    } ffa_result_t;

    // log2 of the largest power of two (up to 32) dividing alignment and header
    // size, 0 if both divide by 64; every block offset is a multiple of it
    function automatic int gran_shift(input int a, input int h);
        int v;
        int s;
        int k;
        v = a | h;
        s = 0;
        for (k = 5; k >= 0; k--)
        begin
            if (((v >> k) & 1) != 0)
            begin
                s = k;
            end
        end
        return s;
    endfunction

endpackage

[hw/rtl/first_fit_free_list_allocator.sv]
// Top level of the first-fit free-list allocator: config register, result
// register, sequencer and header RAMs. Uses ffa_pkg, ffa_ctrl, ffa_ram.
`timescale 1ns / 1ps

// Usage
//   s_* carries one request per handshake: opcode alloc, free or reinit.
//   m_* returns exactly one result per request, in order.
//   cfg_* writes heap_bytes (bytes that reinit turns into one free block);
//   write it only while no request is in work. cfg_ready is always high.
// Sequence per request, from acceptance to the result:
//   unknown opcode, zero-size alloc: straight to the result state ST_RESP;
//   free, reinit: a header write (ST_FREE, ST_REINIT), then ST_RESP;
//   alloc: size rounding (ST_ROUND, ST_SCALE), one header read per visited
//          block (ST_WALK), header write-back (ST_FIT_A, ST_FIT_B) if one
//          fits, then ST_RESP.
//   The next request is taken only after the result is handed to the
//   output register. One request is in work at a time; the walk is bound by
//   the single read port of the header RAMs.
// Reset: the first state after reset, ST_INIT, writes the header at offset 0
//   (whole heap, reset heap size) and points the list head at it; no request
//   is taken in that state. The rest of the header RAMs is not cleared.
// Stall: a result sits in the output register until m_tready; a new request
//   is still taken meanwhile and its result waits in the sequencer.
// HEAP_SIZE_MAX must be a power of two; offsets wrap modulo it.

module first_fit_free_list_allocator import ffa_pkg::*; #(
    parameter int HEAP_SIZE_MAX = HEAP_SIZE_MAX_DEF,
    parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES   = ALIGN_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // opcode[1:0], req_size[17:2], free_addr[29:18]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // ok[0], payload_addr[12:1]
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data   // heap_bytes
);

    localparam int OFF_W  = $clog2(HEAP_SIZE_MAX);
    localparam int GS     = gran_shift(ALIGN_BYTES, HEADER_BYTES);
    localparam int IDX_W  = OFF_W - GS;
    localparam int SIZE_W = OFF_W;
    localparam int DEPTH  = 2 ** IDX_W;

    logic [CFG_W-1:0]  heap_bytes_reg, heap_bytes_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    logic              res_valid;
    logic              res_ready;
    ffa_result_t       res;

    // header RAM ports
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [SIZE_W-1:0] sz_rd_data;
    logic [IDX_W:0]    lk_rd_data;
    logic              sz_we;
    logic [IDX_W-1:0]  sz_wr_idx;
    logic [SIZE_W-1:0] sz_wr_data;
    logic              lk_we;
    logic [IDX_W-1:0]  lk_wr_idx;
    logic [IDX_W:0]    lk_wr_data;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // output register frees up when empty or taken this cycle
    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        heap_bytes_next = cfg_valid ? cfg_data : heap_bytes_reg;
        m_data_next     = m_data_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'(res);
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_bytes_reg <= CFG_W'(HEAP_BYTES_RST);
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end
        else
        begin
            heap_bytes_reg <= heap_bytes_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
        end
    end

    ffa_ctrl #(
        .HEAP_SIZE_MAX (HEAP_SIZE_MAX),
        .HEADER_BYTES  (HEADER_BYTES),
        .ALIGN_BYTES   (ALIGN_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_opcode    (s_tdata[1:0]),
        .in_req_size  (s_tdata[17:2]),
        .in_free_addr (s_tdata[29:18]),
        .heap_bytes   (heap_bytes_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .rd_en        (rd_en),
        .rd_idx       (rd_idx),
        .sz_rd_data   (sz_rd_data),
        .lk_rd_data   (lk_rd_data),
        .sz_we        (sz_we),
        .sz_wr_idx    (sz_wr_idx),
        .sz_wr_data   (sz_wr_data),
        .lk_we        (lk_we),
        .lk_wr_idx    (lk_wr_idx),
        .lk_wr_data   (lk_wr_data)
    );

    // block payload sizes, one entry per granule offset
    ffa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (DEPTH)
    ) u_size_ram (
        .clk     (clk),
        .we      (sz_we),
        .wr_addr (sz_wr_idx),
        .wr_data (sz_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx),
        .rd_data (sz_rd_data)
    );

    // next-free links: {valid, index}
    ffa_ram #(
        .WIDTH (IDX_W + 1),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .we      (lk_we),
        .wr_addr (lk_wr_idx),
        .wr_data (lk_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx),
        .rd_data (lk_rd_data)
    );

endmodule

[hw/rtl/ffa_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/ffa_ctrl.sv]
// Allocator sequencer: request decode, size rounding, free-list walk and
// header read-modify-write over the size and link RAMs. Uses ffa_pkg.
`timescale 1ns / 1ps

module ffa_ctrl import ffa_pkg::*; #(
    parameter int HEAP_SIZE_MAX = HEAP_SIZE_MAX_DEF,
    parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES   = ALIGN_BYTES_DEF,
    localparam int OFF_W        = $clog2(HEAP_SIZE_MAX),
    localparam int GS           = gran_shift(ALIGN_BYTES, HEADER_BYTES),
    localparam int IDX_W        = OFF_W - GS,
    localparam int SIZE_W       = OFF_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OPC_W-1:0]   in_opcode,
    input  logic [REQ_W-1:0]   in_req_size,
    input  logic [ADDR_W-1:0]  in_free_addr,
    input  logic [CFG_W-1:0]   heap_bytes,
    output logic               res_valid,
    input  logic               res_ready,
    output ffa_result_t        res,
    output logic               rd_en,
    output logic [IDX_W-1:0]   rd_idx,
    input  logic [SIZE_W-1:0]  sz_rd_data,
    input  logic [IDX_W:0]     lk_rd_data,
    output logic               sz_we,
    output logic [IDX_W-1:0]   sz_wr_idx,
    output logic [SIZE_W-1:0]  sz_wr_data,
    output logic               lk_we,
    output logic [IDX_W-1:0]   lk_wr_idx,
    output logic [IDX_W:0]     lk_wr_data
);

    localparam int LIM_W       = NEED_W + 1;
    localparam int WALK_LIMIT  = HEAP_SIZE_MAX / ALIGN_BYTES + 1;
    localparam int STEP_W      = $clog2(WALK_LIMIT + 1);
    // exact floor(x / ALIGN_BYTES) for x below 2**NEED_W
    localparam int RECIP_SHIFT = NEED_W + 4;
    localparam int RECIP       = (2 ** RECIP_SHIFT + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int PROD_W      = RECIP_SHIFT + NEED_W;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_REINIT,
        ST_FREE,
        ST_ROUND,
        ST_SCALE,
        ST_WALK,
        ST_FIT_A,
        ST_FIT_B,
        ST_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [ADDR_W-1:0]   faddr_reg, faddr_next;
    logic [NEED_W-1:0]   q_reg, q_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [LIM_W-1:0]    need_h_reg, need_h_next;
    logic [LIM_W-1:0]    need_lim_reg, need_lim_next;
    logic [IDX_W-1:0]    head_off_reg, head_off_next;
    logic                head_vld_reg, head_vld_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic                prev_vld_reg, prev_vld_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic [SIZE_W-1:0]   hdr_size_reg, hdr_size_next;
    logic [IDX_W:0]      hdr_link_reg, hdr_link_next;
    logic                split_reg, split_next;
    logic                res_ok_reg, res_ok_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;

    logic [NEED_W-1:0]   round_x;
    logic [PROD_W-1:0]   round_prod;
    logic [NEED_W-1:0]   need_v;
    logic [OFF_W-1:0]    cur_off;
    logic [31:0]         rest_sum;
    logic [31:0]         pay_sum;
    logic [31:0]         blk_sum;
    logic [OFF_W-1:0]    rest_off;
    logic [OFF_W-1:0]    pay_off;
    logic [OFF_W-1:0]    blk_off;
    logic [IDX_W-1:0]    rest_idx;
    logic [IDX_W-1:0]    blk_idx;
    logic [SIZE_W-1:0]   rest_size;
    logic                fits;

    function automatic logic [SIZE_W-1:0] reinit_size(input logic [CFG_W-1:0] hb);
        logic [31:0] total;
        total = (32'(hb) > 32'(HEAP_SIZE_MAX)) ? 32'(HEAP_SIZE_MAX) : 32'(hb);
        return (total >= 32'(HEADER_BYTES)) ? SIZE_W'(total - 32'(HEADER_BYTES)) : '0;
    endfunction

    // datapath
    assign round_x    = NEED_W'(req_reg) + NEED_W'(ALIGN_BYTES - 1);
    assign round_prod = PROD_W'(round_x) * PROD_W'(RECIP);
    assign need_v     = NEED_W'(32'(q_reg) * 32'(ALIGN_BYTES));
    assign cur_off    = OFF_W'(cur_reg) << GS;
    assign rest_sum   = 32'(cur_off) + 32'(need_h_reg);
    assign pay_sum    = 32'(cur_off) + 32'(HEADER_BYTES);
    assign blk_sum    = 32'(faddr_reg) - 32'(HEADER_BYTES);
    assign rest_off   = rest_sum[OFF_W-1:0];
    assign pay_off    = pay_sum[OFF_W-1:0];
    assign blk_off    = blk_sum[OFF_W-1:0];
    assign rest_idx   = rest_off[OFF_W-1:GS];
    assign blk_idx    = blk_off[OFF_W-1:GS];
    assign rest_size  = SIZE_W'(LIM_W'(hdr_size_reg) - need_h_reg);
    assign fits       = LIM_W'(sz_rd_data) >= LIM_W'(need_reg);

    assign res = '{addr: res_addr_reg, ok: res_ok_reg};

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        faddr_next    = faddr_reg;
        q_next        = q_reg;
        need_next     = need_reg;
        need_h_next   = need_h_reg;
        need_lim_next = need_lim_reg;
        head_off_next = head_off_reg;
        head_vld_next = head_vld_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        prev_vld_next = prev_vld_reg;
        steps_next    = steps_reg;
        hdr_size_next = hdr_size_reg;
        hdr_link_next = hdr_link_reg;
        split_next    = split_reg;
        res_ok_next   = res_ok_reg;
        res_addr_next = res_addr_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        rd_en         = 1'b0;
        rd_idx        = '0;
        sz_we         = 1'b0;
        sz_wr_idx     = '0;
        sz_wr_data    = '0;
        lk_we         = 1'b0;
        lk_wr_idx     = '0;
        lk_wr_data    = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                // header at offset 0 as after a reinit with the reset heap size
                sz_we         = 1'b1;
                sz_wr_data    = reinit_size(CFG_W'(HEAP_BYTES_RST));
                lk_we         = 1'b1;
                head_off_next = '0;
                head_vld_next = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next      = in_req_size;
                    faddr_next    = in_free_addr;
                    res_ok_next   = 1'b0;
                    res_addr_next = '0;
                    unique case (in_opcode)
                        OP_ALLOC:  state_next = (in_req_size != '0) ? ST_ROUND : ST_RESP;
                        OP_FREE:   state_next = ST_FREE;
                        OP_REINIT: state_next = ST_REINIT;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_REINIT:
            begin
                sz_we         = 1'b1;
                sz_wr_data    = reinit_size(heap_bytes);
                lk_we         = 1'b1;
                head_off_next = '0;
                head_vld_next = 1'b1;
                res_ok_next   = 1'b1;
                state_next    = ST_RESP;
            end
            ST_FREE:
            begin
                // push on list head; size field of the block is kept
                lk_we         = 1'b1;
                lk_wr_idx     = blk_idx;
                lk_wr_data    = {head_vld_reg, head_off_reg};
                head_off_next = blk_idx;
                head_vld_next = 1'b1;
                res_ok_next   = 1'b1;
                state_next    = ST_RESP;
            end
            ST_ROUND:
            begin
                q_next     = round_prod[RECIP_SHIFT +: NEED_W];
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                need_next     = need_v;
                need_h_next   = LIM_W'(need_v) + LIM_W'(HEADER_BYTES);
                need_lim_next = LIM_W'(need_v) + LIM_W'(HEADER_BYTES + ALIGN_BYTES);
                cur_next      = head_off_reg;
                prev_vld_next = 1'b0;
                steps_next    = STEP_W'(1);
                if (head_vld_reg)
                begin
                    rd_en      = 1'b1;
                    rd_idx     = head_off_reg;
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_WALK:
            begin
                // header of cur_reg is on the RAM outputs
                if (fits)
                begin
                    hdr_size_next = sz_rd_data;
                    hdr_link_next = lk_rd_data;
                    split_next    = LIM_W'(sz_rd_data) >= need_lim_reg;
                    state_next    = ST_FIT_A;
                end
                else if (lk_rd_data[IDX_W] && (steps_reg < STEP_W'(WALK_LIMIT)))
                begin
                    rd_en         = 1'b1;
                    rd_idx        = lk_rd_data[IDX_W-1:0];
                    prev_next     = cur_reg;
                    prev_vld_next = 1'b1;
                    cur_next      = lk_rd_data[IDX_W-1:0];
                    steps_next    = steps_reg + STEP_W'(1);
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_FIT_A:
            begin
                if (split_reg)
                begin
                    // remainder header
                    sz_we      = 1'b1;
                    sz_wr_idx  = rest_idx;
                    sz_wr_data = rest_size;
                    lk_we      = 1'b1;
                    lk_wr_idx  = rest_idx;
                    lk_wr_data = hdr_link_reg;
                end
                else if (prev_vld_reg)
                begin
                    lk_we      = 1'b1;
                    lk_wr_idx  = prev_reg;
                    lk_wr_data = hdr_link_reg;
                end
                else
                begin
                    head_off_next = hdr_link_reg[IDX_W-1:0];
                    head_vld_next = hdr_link_reg[IDX_W];
                end
                state_next = ST_FIT_B;
            end
            ST_FIT_B:
            begin
                if (split_reg)
                begin
                    if (prev_vld_reg)
                    begin
                        lk_we      = 1'b1;
                        lk_wr_idx  = prev_reg;
                        lk_wr_data = {1'b1, rest_idx};
                    end
                    else
                    begin
                        head_off_next = rest_idx;
                        head_vld_next = 1'b1;
                    end
                    sz_we      = 1'b1;
                    sz_wr_idx  = cur_reg;
                    sz_wr_data = SIZE_W'(need_reg);
                end
                else
                begin
                    lk_we     = 1'b1;
                    lk_wr_idx = cur_reg;
                end
                res_ok_next   = 1'b1;
                res_addr_next = ADDR_W'(32'(pay_off));
                state_next    = ST_RESP;
            end
            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            req_reg      <= '0;
            faddr_reg    <= '0;
            q_reg        <= '0;
            need_reg     <= '0;
            need_h_reg   <= '0;
            need_lim_reg <= '0;
            head_off_reg <= '0;
            head_vld_reg <= 1'b1;
            cur_reg      <= '0;
            prev_reg     <= '0;
            prev_vld_reg <= 1'b0;
            steps_reg    <= '0;
            hdr_size_reg <= '0;
            hdr_link_reg <= '0;
            split_reg    <= 1'b0;
            res_ok_reg   <= 1'b0;
            res_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            req_reg      <= req_next;
            faddr_reg    <= faddr_next;
            q_reg        <= q_next;
            need_reg     <= need_next;
            need_h_reg   <= need_h_next;
            need_lim_reg <= need_lim_next;
            head_off_reg <= head_off_next;
            head_vld_reg <= head_vld_next;
            cur_reg      <= cur_next;
            prev_reg     <= prev_next;
            prev_vld_reg <= prev_vld_next;
            steps_reg    <= steps_next;
            hdr_size_reg <= hdr_size_next;
            hdr_link_reg <= hdr_link_next;
            split_reg    <= split_next;
            res_ok_reg   <= res_ok_next;
            res_addr_reg <= res_addr_next;
        end
    end

endmodule

[hw/rtl/ffa_checker.sv]
// Port-level checks for the allocator, bound to the top level.
// Depends on first_fit_free_list_allocator.
`timescale 1ns / 1ps

module ffa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // failed result carries a null address
    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[12:1] == 12'd0)
        else $error("failed result with nonzero address");

    // a new result only comes out of work in progress
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
